// ===== src/dds_pkg.sv =====
// shared types and constants for the dive depth schedule and twist block
// no dependencies; imported by every module of the block
`default_nettype none

package dds_pkg;

	localparam int DEF_FRAC_BITS = 16;
	localparam int GAIN_FRAC     = 8;
	localparam int ROT_FRAC      = 14;

	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 17;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	localparam int CFG_IDX_W = 3;
	localparam int IN_W      = 240;
	localparam int OUT_W     = 104;

	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_DEPTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SURFACE_DEPTH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_HOLD    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SURFACE_HOLD  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_VSPEED    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_GAIN    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_TICK_DURATION = 3'd6;

	localparam logic [31:0] TICK_RESET = 32'd6554;
	localparam logic [15:0] GAIN_RESET = 16'd256;

	typedef enum logic [1:0] {
		PH_DESCEND   = 2'd0,
		PH_HOLD_DEPTH = 2'd1,
		PH_ASCEND    = 2'd2,
		PH_HOLD_SURF = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		SQ_IDLE,
		SQ_SCHED,
		SQ_GAIN,
		SQ_SPEED,
		SQ_ROT,
		SQ_DRAIN,
		SQ_OUT
	} seq_state_t;

	typedef struct packed {
		logic       in_ready;
		logic       sched_en;
		logic       speed_en;
		logic       rot_issue;
		logic [1:0] row;
		logic [1:0] col;
		logic       out_load;
	} seq_ctrl_t;

endpackage

`default_nettype wire

// ===== src/dds_mul.sv =====
// shared signed multiplier with registered product
// depends on dds_pkg for operand and product widths
`default_nettype none

module dds_mul (
	input  wire logic                                clk,
	input  wire logic signed [dds_pkg::MUL_A_W-1:0]  a,
	input  wire logic signed [dds_pkg::MUL_B_W-1:0]  b,
	output logic signed [dds_pkg::PROD_W-1:0]        p_q
);
	import dds_pkg::*;

	// operands sign-extended to the product width so the full product is kept
	always_ff @(posedge clk) begin
		p_q <= PROD_W'(a) * PROD_W'(b);
	end

endmodule

`default_nettype wire

// ===== src/dds_seq.sv =====
// step sequencer: schedule, gain product, speed limit, nine rotation products
// depends on dds_pkg for the state enum and control struct
`default_nettype none

module dds_seq (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          out_free,
	output dds_pkg::seq_ctrl_t ctrl
);
	import dds_pkg::*;

	seq_state_t state_q, state_d;
	logic [1:0] row_q, col_q;
	logic       last_term;

	assign last_term = (row_q == 2'd2) && (col_q == 2'd2);

	always_comb begin
		state_d = state_q;
		case (state_q)
			SQ_IDLE:  if (in_valid) state_d = SQ_SCHED;
			SQ_SCHED: state_d = SQ_GAIN;
			SQ_GAIN:  state_d = SQ_SPEED;
			SQ_SPEED: state_d = SQ_ROT;
			SQ_ROT:   if (last_term) state_d = SQ_DRAIN;
			SQ_DRAIN: state_d = SQ_OUT;
			SQ_OUT:   if (out_free) state_d = SQ_IDLE;
			default:  state_d = SQ_IDLE;
		endcase
	end

	always_comb begin
		ctrl           = '0;
		ctrl.row       = row_q;
		ctrl.col       = col_q;
		case (state_q)
			SQ_IDLE:  ctrl.in_ready  = 1'b1;
			SQ_SCHED: ctrl.sched_en  = 1'b1;
			SQ_SPEED: ctrl.speed_en  = 1'b1;
			SQ_ROT:   ctrl.rot_issue = 1'b1;
			SQ_OUT:   ctrl.out_load  = out_free;
			default:  ctrl.in_ready  = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
			row_q   <= '0;
			col_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == SQ_ROT) begin
				if (row_q == 2'd2) begin
					row_q <= '0;
					col_q <= last_term ? 2'd0 : col_q + 2'd1;
				end else begin
					row_q <= row_q + 2'd1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/dive_depth_schedule_twist_top.sv =====
// dive depth schedule with world-to-body velocity rotation, top level
// depends on dds_pkg, dds_mul and dds_seq
//
// channel  dir  handshake          payload
// s_       in   s_tvalid/s_tready  s_tdata: depth, current_x, current_y, rot_00..rot_22
// m_       out  m_tvalid/m_tready  m_tdata: body_vx, body_vy, body_vz, dive_phase
// cfg_     in   cfg_valid/cfg_ready cfg_index, cfg_data (always ready)
//
// a word runs from acceptance to result through one schedule step, then ten
// products through the single shared multiplier (gain, nine rotation terms) and a drain
// step for the last accumulation; the next word is taken once the sequencer is idle
// a finished result waits in the output register while the next word is accepted
// asynchronous reset clears schedule state, sequencer, output valid and configuration registers to their defaults
`default_nettype none

module dive_depth_schedule_twist_top #(
	parameter int FRAC_BITS = dds_pkg::DEF_FRAC_BITS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// depth[31:0], current_x[63:32], current_y[95:64], rot_00..rot_22 16 bits each
	// from bit 96 up, row major
	input  wire logic [dds_pkg::IN_W-1:0]      s_tdata,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// body_vx[31:0], body_vy[63:32], body_vz[95:64], dive_phase[97:96], zero fill
	output logic [dds_pkg::OUT_W-1:0]          m_tdata,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [dds_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]                   cfg_data
);
	import dds_pkg::*;

	localparam logic [31:0] TARGET_RESET = 32'(10) << FRAC_BITS;
	localparam logic [31:0] HOLD_RESET   = 32'(10) << FRAC_BITS;
	localparam logic [30:0] VMAX_RESET   = 31'(1) << (FRAC_BITS - 1);

	// configuration registers
	logic signed [31:0] tgt_q, surf_q;
	logic [31:0]        dhold_q, shold_q, tick_q;
	logic [30:0]        vmax_q;
	logic [15:0]        gain_q;

	// schedule state
	phase_t      phase_q;
	logic [31:0] elapsed_q;

	// latched input word
	logic signed [31:0] depth_q, cx_q, cy_q;
	logic signed [15:0] rot_q [3][3];

	// working registers
	logic               moving_q, neg_q;
	logic [31:0]        err_q;
	logic signed [31:0] vz_q;
	logic signed [PROD_W-1:0] acc_q;
	logic signed [31:0] res_q [3];
	logic               acc_en_s1;
	logic [1:0]         row_s1, col_s1;

	seq_ctrl_t ctrl;
	logic      out_free;

	assign cfg_ready = 1'b1;
	assign s_tready  = ctrl.in_ready;
	assign out_free  = !m_tvalid || m_tready;

	dds_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.out_free (out_free),
		.ctrl     (ctrl)
	);

	// configuration writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_q   <= TARGET_RESET;
			surf_q  <= '0;
			dhold_q <= HOLD_RESET;
			shold_q <= HOLD_RESET;
			vmax_q  <= VMAX_RESET;
			gain_q  <= GAIN_RESET;
			tick_q  <= TICK_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TARGET_DEPTH:  tgt_q   <= cfg_data;
				CFG_SURFACE_DEPTH: surf_q  <= cfg_data;
				CFG_DEPTH_HOLD:    dhold_q <= cfg_data;
				CFG_SURFACE_HOLD:  shold_q <= cfg_data;
				CFG_MAX_VSPEED:    vmax_q  <= cfg_data[30:0];
				CFG_DEPTH_GAIN:    gain_q  <= cfg_data[15:0];
				CFG_TICK_DURATION: tick_q  <= cfg_data;
				default:           ;
			endcase
		end
	end

	// input word capture
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			depth_q <= s_tdata[31:0];
			cx_q    <= s_tdata[63:32];
			cy_q    <= s_tdata[95:64];
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					rot_q[r][c] <= s_tdata[96 + 16*(3*r + c) +: 16];
				end
			end
		end
	end

	// schedule step
	logic [32:0] tick_sum;
	logic [31:0] elapsed_sat;
	logic [32:0] d_tgt, d_surf;
	logic        at_target, at_surface;

	assign tick_sum    = {1'b0, elapsed_q} + {1'b0, tick_q};
	assign elapsed_sat = tick_sum[32] ? '1 : tick_sum[31:0];
	assign d_tgt       = {tgt_q[31], tgt_q} - {depth_q[31], depth_q};
	assign d_surf      = {depth_q[31], depth_q} - {surf_q[31], surf_q};
	assign at_target   = depth_q >= tgt_q;
	assign at_surface  = depth_q <= surf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_DESCEND;
			elapsed_q <= '0;
			moving_q  <= 1'b0;
			neg_q     <= 1'b0;
		end else if (ctrl.sched_en) begin
			moving_q <= 1'b0;
			neg_q    <= 1'b0;
			case (phase_q)
				PH_DESCEND: begin
					if (at_target) begin
						phase_q   <= PH_HOLD_DEPTH;
						elapsed_q <= '0;
					end else begin
						moving_q <= 1'b1;
					end
				end
				PH_HOLD_DEPTH: begin
					elapsed_q <= elapsed_sat;
					if (elapsed_sat >= dhold_q) phase_q <= PH_ASCEND;
				end
				PH_ASCEND: begin
					if (at_surface) begin
						phase_q   <= PH_HOLD_SURF;
						elapsed_q <= '0;
					end else begin
						moving_q <= 1'b1;
						neg_q    <= 1'b1;
					end
				end
				default: begin
					elapsed_q <= elapsed_sat;
					if (elapsed_sat >= shold_q) phase_q <= PH_DESCEND;
				end
			endcase
		end
	end

	// depth error, positive whenever the vehicle is moving
	always_ff @(posedge clk) begin
		if (ctrl.sched_en) begin
			err_q <= (phase_q == PH_ASCEND) ? d_surf[31:0] : d_tgt[31:0];
		end
	end

	// shared multiplier operands: gain product first, then the transposed rotation
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [31:0]        w_sel;
	logic signed [15:0]        r_sel;
	logic signed [PROD_W-1:0]  prod_q;

	always_comb begin
		case (ctrl.row)
			2'd0:    w_sel = cx_q;
			2'd1:    w_sel = cy_q;
			default: w_sel = vz_q;
		endcase
		// body_i takes column i of the matrix
		r_sel = rot_q[ctrl.row][ctrl.col];
		if (ctrl.rot_issue) begin
			mul_a = {w_sel[31], w_sel};
			mul_b = {r_sel[15], r_sel};
		end else begin
			mul_a = {1'b0, err_q};
			mul_b = {1'b0, gain_q};
		end
	end

	dds_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod_q)
	);

	// speed command: truncating shift of the gain product, limited, signed by direction
	logic [PROD_W-GAIN_FRAC-1:0] p_sh;
	logic [30:0]                 mag;
	logic [31:0]                 vz_abs;

	assign p_sh   = prod_q[PROD_W-1:GAIN_FRAC];
	assign mag    = (p_sh > (PROD_W-GAIN_FRAC)'(vmax_q)) ? vmax_q : p_sh[30:0];
	assign vz_abs = vz_q[31] ? 32'(-vz_q) : vz_q;

	always_ff @(posedge clk) begin
		if (ctrl.speed_en) begin
			if (!moving_q)  vz_q <= '0;
			else if (neg_q) vz_q <= -$signed({1'b0, mag});
			else            vz_q <= $signed({1'b0, mag});
		end
	end

	// rotation accumulation, its enable and indices registered in step with the multiplier product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_en_s1 <= 1'b0;
		end else begin
			acc_en_s1 <= ctrl.rot_issue;
		end
	end

	always_ff @(posedge clk) begin
		row_s1 <= ctrl.row;
		col_s1 <= ctrl.col;
	end

	logic signed [PROD_W-1:0]          acc_sum;
	logic signed [PROD_W-ROT_FRAC-1:0] q_fl;
	logic signed [31:0]                q_sat;

	assign acc_sum = ((row_s1 == 2'd0) ? '0 : acc_q) + prod_q;
	// arithmetic shift gives the floor of the quotient
	assign q_fl    = acc_sum[PROD_W-1:ROT_FRAC];

	always_comb begin
		if (q_fl[PROD_W-ROT_FRAC-1:31] == '0 || q_fl[PROD_W-ROT_FRAC-1:31] == '1) begin
			q_sat = q_fl[31:0];
		end else if (q_fl[PROD_W-ROT_FRAC-1]) begin
			q_sat = 32'sh8000_0000;
		end else begin
			q_sat = 32'sh7FFF_FFFF;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_en_s1) begin
			acc_q <= acc_sum;
			if (row_s1 == 2'd2) res_q[col_s1] <= q_sat;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (ctrl.out_load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			m_tdata <= {6'b0, phase_q, res_q[2], res_q[1], res_q[0]};
		end
	end

	// phase moves only on the schedule step
	a_phase_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!ctrl.sched_en |=> $stable(phase_q))
		else $error("phase changed outside schedule step");

	// leaving descend starts the hold with a cleared timer
	a_hold_clear: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.sched_en && phase_q == PH_DESCEND |=>
		(phase_q == PH_DESCEND || elapsed_q == '0))
		else $error("elapsed time not cleared on entering depth hold");

	// no vertical command in the hold phases
	a_hold_still: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.sched_en && (phase_q == PH_HOLD_DEPTH || phase_q == PH_HOLD_SURF) |=>
		!moving_q)
		else $error("vertical command requested while holding");

	// speed command stays within the limit
	a_vz_limit: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.speed_en |=> vz_abs <= {1'b0, vmax_q})
		else $error("vertical speed exceeds limit");

	// the last rotation term is folded in before the result is loaded
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.out_load |-> !acc_en_s1)
		else $error("result loaded with accumulation pending");

endmodule

`default_nettype wire
